FILE: rtl/rational_add_mult_reduce_core_macros.svh
// Assertion macros shared by the rational arithmetic core RTL.
`ifndef RATIONAL_ADD_MULT_REDUCE_CORE_MACROS_SVH
`define RATIONAL_ADD_MULT_REDUCE_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define RARMR_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rarmr assertion failed");
`define RARMR_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rarmr assertion failed");
`else
`define RARMR_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define RARMR_ASSERT_NXT(lbl, clk, rst, ante, cons)
`endif
`endif

FILE: rtl/rarmr_pkg.sv
// Command codes of the rational arithmetic core.
package rarmr_pkg;
   localparam logic [1:0] CMD_ADD = 2'd0;
   localparam logic [1:0] CMD_MUL = 2'd1;
   localparam logic [1:0] CMD_CMP = 2'd2;
endpackage

FILE: rtl/rarmr_div.sv
// Radix-2 restoring unsigned divider, one quotient bit per cycle.
`include "rational_add_mult_reduce_core_macros.svh"
module rarmr_div #(
   parameter int DW = 64
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [DW-1:0] dividend,
   input  logic [DW-1:0] divisor,
   output logic          done,
   output logic [DW-1:0] quotient,
   output logic [DW-1:0] remainder
);
   localparam int CW = $clog2(DW + 1);

   logic [DW-1:0] quo_ff, rem_ff, dvs_ff;
   logic [CW-1:0] cnt_ff;
   logic          busy_ff, done_ff;
   logic [DW:0]   shift_w, diff_w;

   assign shift_w = {rem_ff, quo_ff[DW-1]};
   assign diff_w  = shift_w - {1'b0, dvs_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (start) begin
         quo_ff  <= dividend;
         rem_ff  <= '0;
         dvs_ff  <= divisor;
         cnt_ff  <= CW'(DW);
         busy_ff <= 1'b1;
         done_ff <= 1'b0;
      end else if (busy_ff) begin
         if (!diff_w[DW]) begin
            rem_ff <= diff_w[DW-1:0];
            quo_ff <= {quo_ff[DW-2:0], 1'b1};
         end else begin
            rem_ff <= shift_w[DW-1:0];
            quo_ff <= {quo_ff[DW-2:0], 1'b0};
         end
         cnt_ff <= cnt_ff - CW'(1);
         if (cnt_ff == CW'(1)) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end else begin
         done_ff <= 1'b0;
      end
   end

   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

   `RARMR_ASSERT_IMP(a_div_no_restart, clock, reset, start, !busy_ff)
   `RARMR_ASSERT_NXT(a_div_finish, clock, reset, busy_ff && !start && cnt_ff == CW'(1), done_ff)
   `RARMR_ASSERT_IMP(a_div_done_idle, clock, reset, done_ff, !busy_ff)
endmodule

FILE: rtl/rational_add_mult_reduce_core.sv
// Top level of the rational add, multiply and compare core.
// One item at a time: req_stall is high from acceptance until the result word is taken.
// Each normalization runs the Euclidean GCD on the shared divider, one division per
// remainder step, then two more divisions by the GCD; an item takes four
// normalizations for add (both operands, the denominator pair and the sum),
// three for multiply and two for compare.
`include "rational_add_mult_reduce_core_macros.svh"
module rational_add_mult_reduce_core #(
   parameter int WIDTH = 32
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [1:0]         req_cmd,
   input  logic signed [31:0] req_a_num,
   input  logic signed [31:0] req_a_den,
   input  logic signed [31:0] req_b_num,
   input  logic signed [31:0] req_b_den,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [31:0] rsp_res_num,
   output logic [30:0]        rsp_res_den,
   output logic               rsp_is_equal,
   output logic               rsp_overflow
);
   localparam int DW = 2 * WIDTH;
   localparam logic [DW-1:0] LIMIT = (DW'(1) << (WIDTH - 1)) - DW'(1);

   typedef enum logic [3:0] {
      S_IDLE, S_NORM, S_GCD, S_GMOD, S_DIVN, S_DIVD, S_NDONE,
      S_MUL1, S_MUL2, S_ADD1, S_ADD2, S_ADD3, S_ADD4, S_DONE
   } state_type;
   typedef enum logic [1:0] {P_A, P_B, P_ADD, P_RES} phase_type;

   state_type  state_ff;
   phase_type  phase_ff;
   logic [1:0] cmd_ff;
   logic [WIDTH-1:0] an_ff, ad_ff, bn_ff, bd_ff;
   logic sa_ff, sb_ff, rs_ff;
   logic [DW-1:0] rn_ff, rd_ff, gx_ff, gy_ff;
   logic          rsp_valid_ff, eq_ff, ovf_ff;
   logic [31:0]   num_ff;
   logic [30:0]   den_ff;

   logic             div_start, div_done;
   logic [DW-1:0]    div_dividend, div_divisor, div_quo, div_rem;
   logic [WIDTH-1:0] mul_a, mul_b;
   logic [DW-1:0]    product;
   logic [WIDTH-1:0] an_in, ad_in, bn_in, bd_in;
   logic             an_neg, ad_neg, bn_neg, bd_neg;
   logic [31:0]      mag32;

   function automatic logic [WIDTH-1:0] mag_of(input logic [31:0] raw);
      logic [WIDTH-1:0] v;
      v = raw[WIDTH-1:0];
      return v[WIDTH-1] ? (~v + WIDTH'(1)) : v;
   endfunction

   assign an_in  = mag_of(req_a_num);
   assign ad_in  = mag_of(req_a_den);
   assign bn_in  = mag_of(req_b_num);
   assign bd_in  = mag_of(req_b_den);
   assign an_neg = req_a_num[WIDTH-1];
   assign ad_neg = req_a_den[WIDTH-1];
   assign bn_neg = req_b_num[WIDTH-1];
   assign bd_neg = req_b_den[WIDTH-1];

   always_comb begin
      mul_a = an_ff;
      mul_b = bn_ff;
      case (state_ff)
         S_MUL2: begin mul_a = ad_ff;            mul_b = bd_ff;            end
         S_ADD1: begin mul_a = an_ff;            mul_b = rd_ff[WIDTH-1:0]; end
         S_ADD2: begin mul_a = bn_ff;            mul_b = rn_ff[WIDTH-1:0]; end
         S_ADD3: begin mul_a = rn_ff[WIDTH-1:0]; mul_b = bd_ff;            end
         default: begin mul_a = an_ff;           mul_b = bn_ff;            end
      endcase
   end
   assign product = DW'(mul_a) * DW'(mul_b);

   always_comb begin
      div_start    = 1'b0;
      div_dividend = gx_ff;
      div_divisor  = gy_ff;
      case (state_ff)
         S_GCD: begin
            div_start = 1'b1;
            if (gy_ff == '0) begin
               div_dividend = rn_ff;
               div_divisor  = gx_ff;
            end
         end
         S_DIVN: begin
            div_start    = div_done;
            div_dividend = rd_ff;
            div_divisor  = gx_ff;
         end
         default: div_start = 1'b0;
      endcase
   end

   rarmr_div #(.DW(DW)) u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_dividend),
      .divisor   (div_divisor),
      .done      (div_done),
      .quotient  (div_quo),
      .remainder (div_rem)
   );

   assign mag32 = 32'(rn_ff[WIDTH-1:0]);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         phase_ff     <= P_A;
         rsp_valid_ff <= 1'b0;
      end else begin
         case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  cmd_ff   <= req_cmd;
                  rn_ff    <= DW'(an_in);
                  rd_ff    <= DW'(ad_in);
                  rs_ff    <= an_neg ^ ad_neg;
                  bn_ff    <= bn_in;
                  bd_ff    <= bd_in;
                  sb_ff    <= bn_neg ^ bd_neg;
                  phase_ff <= P_A;
                  state_ff <= S_NORM;
               end
            end
            S_NORM: begin
               if (rn_ff == '0 || rd_ff == '0) begin
                  rn_ff    <= '0;
                  rd_ff    <= DW'(1);
                  rs_ff    <= 1'b0;
                  state_ff <= S_NDONE;
               end else begin
                  gx_ff    <= rn_ff;
                  gy_ff    <= rd_ff;
                  state_ff <= S_GCD;
               end
            end
            S_GCD: begin
               state_ff <= (gy_ff == '0) ? S_DIVN : S_GMOD;
            end
            S_GMOD: begin
               if (div_done) begin
                  gx_ff    <= gy_ff;
                  gy_ff    <= div_rem;
                  state_ff <= S_GCD;
               end
            end
            S_DIVN: begin
               if (div_done) begin
                  rn_ff    <= div_quo;
                  state_ff <= S_DIVD;
               end
            end
            S_DIVD: begin
               if (div_done) begin
                  rd_ff    <= div_quo;
                  state_ff <= S_NDONE;
               end
            end
            S_NDONE: begin
               case (phase_ff)
                  P_A: begin
                     an_ff    <= rn_ff[WIDTH-1:0];
                     ad_ff    <= rd_ff[WIDTH-1:0];
                     sa_ff    <= rs_ff;
                     rn_ff    <= DW'(bn_ff);
                     rd_ff    <= DW'(bd_ff);
                     rs_ff    <= sb_ff;
                     phase_ff <= P_B;
                     state_ff <= S_NORM;
                  end
                  P_B: begin
                     bn_ff <= rn_ff[WIDTH-1:0];
                     bd_ff <= rd_ff[WIDTH-1:0];
                     sb_ff <= rs_ff;
                     case (cmd_ff)
                        rarmr_pkg::CMD_ADD: begin
                           rn_ff    <= DW'(ad_ff);
                           phase_ff <= P_ADD;
                           state_ff <= S_NORM;
                        end
                        rarmr_pkg::CMD_MUL: begin
                           state_ff <= S_MUL1;
                        end
                        rarmr_pkg::CMD_CMP: begin
                           eq_ff        <= (sa_ff == rs_ff) && (DW'(an_ff) == rn_ff)
                                           && (DW'(ad_ff) == rd_ff);
                           ovf_ff       <= 1'b0;
                           num_ff       <= '0;
                           den_ff       <= 31'd1;
                           rsp_valid_ff <= 1'b1;
                           state_ff     <= S_DONE;
                        end
                        default: begin
                           eq_ff        <= 1'b0;
                           ovf_ff       <= 1'b0;
                           num_ff       <= '0;
                           den_ff       <= 31'd1;
                           rsp_valid_ff <= 1'b1;
                           state_ff     <= S_DONE;
                        end
                     endcase
                  end
                  P_ADD: begin
                     state_ff <= S_ADD1;
                  end
                  default: begin
                     eq_ff <= 1'b0;
                     if (rn_ff > LIMIT || rd_ff > LIMIT) begin
                        ovf_ff <= 1'b1;
                        num_ff <= '0;
                        den_ff <= 31'd1;
                     end else begin
                        ovf_ff <= 1'b0;
                        num_ff <= rs_ff ? (~mag32 + 32'd1) : mag32;
                        den_ff <= 31'(rd_ff[WIDTH-2:0]);
                     end
                     rsp_valid_ff <= 1'b1;
                     state_ff     <= S_DONE;
                  end
               endcase
            end
            S_MUL1: begin
               rn_ff    <= product;
               rs_ff    <= sa_ff ^ sb_ff;
               state_ff <= S_MUL2;
            end
            S_MUL2: begin
               rd_ff    <= product;
               phase_ff <= P_RES;
               state_ff <= S_NORM;
            end
            S_ADD1: begin
               gx_ff    <= product;
               state_ff <= S_ADD2;
            end
            S_ADD2: begin
               gy_ff    <= product;
               state_ff <= S_ADD3;
            end
            S_ADD3: begin
               rd_ff    <= product;
               state_ff <= S_ADD4;
            end
            S_ADD4: begin
               if (sa_ff == sb_ff) begin
                  rs_ff <= sa_ff;
                  rn_ff <= gx_ff + gy_ff;
               end else if (gx_ff >= gy_ff) begin
                  rs_ff <= sa_ff;
                  rn_ff <= gx_ff - gy_ff;
               end else begin
                  rs_ff <= sb_ff;
                  rn_ff <= gy_ff - gx_ff;
               end
               phase_ff <= P_RES;
               state_ff <= S_NORM;
            end
            S_DONE: begin
               if (!rsp_stall) begin
                  rsp_valid_ff <= 1'b0;
                  state_ff     <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign req_stall    = (state_ff != S_IDLE);
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_res_num  = num_ff;
   assign rsp_res_den  = den_ff;
   assign rsp_is_equal = eq_ff;
   assign rsp_overflow = ovf_ff;

   `RARMR_ASSERT_NXT(a_busy_after_accept, clock, reset, req_valid && !req_stall, req_stall)
   `RARMR_ASSERT_IMP(a_ovf_zero, clock, reset, rsp_valid && rsp_overflow, rsp_res_num == '0 && rsp_res_den == 31'd1)
   `RARMR_ASSERT_IMP(a_eq_no_ovf, clock, reset, rsp_valid && rsp_is_equal, !rsp_overflow)
   `RARMR_ASSERT_IMP(a_den_positive, clock, reset, rsp_valid, rsp_res_den != '0)
endmodule

FILE: sim/rational_add_mult_reduce_core_tb.sv
// Testbench for the rational add, multiply and compare core: directed table plus random words.
`timescale 1ns / 100ps
module rational_add_mult_reduce_core_tb;

   localparam logic [1:0] CMD_NONE = 2'd3;
   localparam logic [63:0] RANGE_MAX = 64'h7FFF_FFFF;
   localparam int RANDOM_WORDS = 1500;

   typedef struct {
      bit         neg;
      bit [63:0]  num;
      bit [63:0]  den;
   } ratio_type;

   typedef struct {
      logic signed [31:0] num;
      logic [30:0]        den;
      logic               eq;
      logic               ovf;
   } sum_type;

   typedef struct {
      logic [1:0]  cmd;
      logic [31:0] an, ad, bn, bd;
      bit          known;
      sum_type     want;
   } row_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic [1:0]         req_cmd = rarmr_pkg::CMD_ADD;
   logic signed [31:0] req_a_num = '0;
   logic signed [31:0] req_a_den = '0;
   logic signed [31:0] req_b_num = '0;
   logic signed [31:0] req_b_den = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic signed [31:0] rsp_res_num;
   logic [30:0]        rsp_res_den;
   logic               rsp_is_equal;
   logic               rsp_overflow;

   sum_type pending_sums[$];
   int   errors = 0;
   int   received = 0;
   int   overflows = 0;
   int   equals = 0;
   int   per_cmd[4] = '{0, 0, 0, 0};
   bit   quiet = 1'b0;

   rational_add_mult_reduce_core #(.WIDTH(32)) dut (.*);

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic bit [63:0] euclid(bit [63:0] x, bit [63:0] y);
      bit [63:0] t;
      while (y != 0) begin
         t = x % y;
         x = y;
         y = t;
      end
      return x;
   endfunction

   function automatic ratio_type reduce(bit nneg, bit [63:0] nmag, bit dneg, bit [63:0] dmag);
      ratio_type r;
      bit [63:0] g;
      if (nmag == 0 || dmag == 0) begin
         r = '{1'b0, 64'd0, 64'd1};
      end else begin
         g = euclid(nmag, dmag);
         r = '{nneg != dneg, nmag / g, dmag / g};
      end
      return r;
   endfunction

   function automatic bit [63:0] magnitude(logic [31:0] v);
      return v[31] ? (64'h1_0000_0000 - {32'd0, v}) : {32'd0, v};
   endfunction

   function automatic ratio_type load_ratio(logic [31:0] n, logic [31:0] d);
      return reduce(n[31], magnitude(n), d[31], magnitude(d));
   endfunction

   function automatic sum_type predict_sum(logic [1:0] cmd, logic [31:0] an, logic [31:0] ad,
                                           logic [31:0] bn, logic [31:0] bd);
      ratio_type a, b, r;
      bit [63:0] l, ta, tb, mag;
      bit neg;
      sum_type s;
      a = load_ratio(an, ad);
      b = load_ratio(bn, bd);
      s = '{32'sd0, 31'd1, 1'b0, 1'b0};
      if (cmd == rarmr_pkg::CMD_ADD || cmd == rarmr_pkg::CMD_MUL) begin
         if (cmd == rarmr_pkg::CMD_ADD) begin
            l = (a.den / euclid(a.den, b.den)) * b.den;
            ta = a.num * (l / a.den);
            tb = b.num * (l / b.den);
            if (a.neg == b.neg) begin
               neg = a.neg;
               mag = ta + tb;
            end else if (ta >= tb) begin
               neg = a.neg;
               mag = ta - tb;
            end else begin
               neg = b.neg;
               mag = tb - ta;
            end
            r = reduce(neg, mag, 1'b0, l);
         end else begin
            r = reduce(a.neg != b.neg, a.num * b.num, 1'b0, a.den * b.den);
         end
         if (r.num > RANGE_MAX || r.den > RANGE_MAX) begin
            s.ovf = 1'b1;
         end else begin
            s.num = r.neg ? -$signed(r.num[31:0]) : $signed(r.num[31:0]);
            s.den = r.den[30:0];
         end
      end else if (cmd == rarmr_pkg::CMD_CMP) begin
         s.eq = (a.neg == b.neg && a.num == b.num && a.den == b.den);
      end
      return s;
   endfunction

   function automatic logic [31:0] pick_operand();
      case ($urandom_range(0, 9))
         0: return 32'd0;
         1: return 32'h8000_0000;
         2: return 32'h7FFF_FFFF;
         3: return $urandom_range(0, 1) ? 32'd1 : 32'hFFFF_FFFF;
         4, 5: return 32'($signed($urandom_range(0, 40)) - 20);
         6, 7: return {{16{1'b0}}, 16'($urandom)} - 32'h8000;
         default: return $urandom;
      endcase
   endfunction

   task automatic send_word(logic [1:0] cmd, logic [31:0] an, logic [31:0] ad,
                            logic [31:0] bn, logic [31:0] bd, bit known, sum_type want);
      req_valid <= 1'b1;
      req_cmd <= cmd;
      req_a_num <= an;
      req_a_den <= ad;
      req_b_num <= bn;
      req_b_den <= bd;
      do @(posedge clock); while (req_stall);
      pending_sums.push_back(known ? want : predict_sum(cmd, an, ad, bn, bd));
      per_cmd[cmd]++;
      if (!quiet && $urandom_range(0, 99) < 7) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
   endtask

   always @(posedge clock) begin
      sum_type w;
      rsp_stall <= !quiet && $urandom_range(0, 99) < 7;
      if (!reset && rsp_valid && !rsp_stall) begin
         received++;
         if (pending_sums.size() == 0) begin
            $error("result word with nothing pending");
            errors++;
         end else begin
            w = pending_sums.pop_front();
            if (rsp_res_num !== w.num) begin
               $error("res_num expected %0d actual %0d", w.num, rsp_res_num);
               errors++;
            end
            if (rsp_res_den !== w.den) begin
               $error("res_den expected %0d actual %0d", w.den, rsp_res_den);
               errors++;
            end
            if (rsp_is_equal !== w.eq) begin
               $error("is_equal expected %0b actual %0b", w.eq, rsp_is_equal);
               errors++;
            end
            if (rsp_overflow !== w.ovf) begin
               $error("overflow expected %0b actual %0b", w.ovf, rsp_overflow);
               errors++;
            end
            overflows += w.ovf;
            equals += w.eq;
         end
      end
   end

   initial begin
      #(2_000_000_000);
      $display("tb: failure");
      $finish;
   end

   initial begin
      row_type rows[$];
      logic [1:0] cmd;
      logic [31:0] an, ad, bn, bd;
      int k;
      sum_type none;
      none = '{32'sd0, 31'd1, 1'b0, 1'b0};
      rows = '{
         '{rarmr_pkg::CMD_ADD, 32'd0, 32'd5, 32'd3, 32'd0, 1'b1, '{32'sd0, 31'd1, 1'b0, 1'b0}},
         '{rarmr_pkg::CMD_ADD, 32'd1, 32'd2, 32'd1, 32'd3, 1'b1, '{32'sd5, 31'd6, 1'b0, 1'b0}},
         '{rarmr_pkg::CMD_ADD, 32'd1, 32'd2, -32'sd1, 32'd2, 1'b1,
           '{32'sd0, 31'd1, 1'b0, 1'b0}},
         '{rarmr_pkg::CMD_MUL, 32'd2, -32'sd4, 32'd3, 32'd1, 1'b1,
           '{-32'sd3, 31'd2, 1'b0, 1'b0}},
         '{rarmr_pkg::CMD_MUL, 32'h7FFF_FFFF, 32'd1, 32'd2, 32'd1, 1'b1,
           '{32'sd0, 31'd1, 1'b0, 1'b1}},
         '{rarmr_pkg::CMD_MUL, 32'h8000_0000, 32'd1, 32'd1, 32'd1, 1'b1,
           '{32'sd0, 31'd1, 1'b0, 1'b1}},
         '{rarmr_pkg::CMD_MUL, 32'h8000_0000, 32'd2, 32'd1, 32'd1, 1'b0, none},
         '{rarmr_pkg::CMD_ADD, 32'h8000_0000, 32'h8000_0000, 32'd0, 32'd1, 1'b1,
           '{32'sd1, 31'd1, 1'b0, 1'b0}},
         '{rarmr_pkg::CMD_ADD, 32'd1, 32'h7FFF_FFFF, 32'd1, 32'h7FFF_FFFE, 1'b0, none},
         '{rarmr_pkg::CMD_ADD, 32'h7FFF_FFFF, 32'd1, 32'h7FFF_FFFF, 32'd1, 1'b0, none},
         '{rarmr_pkg::CMD_ADD, 32'h8000_0001, 32'd1, 32'h8000_0000, 32'h7FFF_FFFF,
           1'b0, none},
         '{rarmr_pkg::CMD_MUL, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h8000_0001, 32'h8000_0001,
           1'b0, none},
         '{rarmr_pkg::CMD_CMP, 32'd1, 32'd2, -32'sd2, -32'sd4, 1'b1,
           '{32'sd0, 31'd1, 1'b1, 1'b0}},
         '{rarmr_pkg::CMD_CMP, 32'd1, 32'd2, 32'd1, 32'd3, 1'b1, none},
         '{rarmr_pkg::CMD_CMP, 32'd0, 32'd7, 32'd9, 32'd0, 1'b1,
           '{32'sd0, 31'd1, 1'b1, 1'b0}},
         '{rarmr_pkg::CMD_CMP, 32'd1, -32'sd2, -32'sd1, 32'd2, 1'b1,
           '{32'sd0, 31'd1, 1'b1, 1'b0}},
         '{rarmr_pkg::CMD_CMP, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
           1'b1, '{32'sd0, 31'd1, 1'b1, 1'b0}},
         '{CMD_NONE, 32'd3, 32'd4, 32'd3, 32'd4, 1'b1, none},
         '{CMD_NONE, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'd0, 1'b1, none},
         '{rarmr_pkg::CMD_ADD, 32'd6, 32'd4, 32'd10, 32'd15, 1'b0, none}
      };
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      quiet = 1'b1;
      foreach (rows[i])
         send_word(rows[i].cmd, rows[i].an, rows[i].ad, rows[i].bn, rows[i].bd,
                   rows[i].known, rows[i].want);
      quiet = 1'b0;
      req_valid <= 1'b0;
      while (pending_sums.size() != 0) @(posedge clock);
      for (int n = 0; n < RANDOM_WORDS; n++) begin
         quiet = (n >= 600 && n < 800);
         k = $urandom_range(0, 99);
         cmd = k < 40 ? rarmr_pkg::CMD_ADD :
               k < 75 ? rarmr_pkg::CMD_MUL :
               k < 95 ? rarmr_pkg::CMD_CMP : CMD_NONE;
         an = pick_operand();
         ad = pick_operand();
         bn = pick_operand();
         bd = pick_operand();
         if (cmd == rarmr_pkg::CMD_CMP && $urandom_range(0, 1)) begin
            an = 32'($signed($urandom_range(0, 2000)) - 1000);
            ad = 32'($signed($urandom_range(0, 2000)) - 1000);
            k = $signed($urandom_range(0, 200)) - 100;
            bn = an * k;
            bd = ad * k;
         end
         send_word(cmd, an, ad, bn, bd, 1'b0, none);
         if (n == 1000) begin
            req_valid <= 1'b0;
            while (pending_sums.size() != 0) @(posedge clock);
         end
      end
      req_valid <= 1'b0;
      while (pending_sums.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      $display("covered %0d add, %0d multiply, %0d compare, %0d unused-command words",
               per_cmd[0], per_cmd[1], per_cmd[2], per_cmd[3]);
      $display("checked %0d results: %0d overflowed, %0d compared equal",
               received, overflows, equals);
      if (errors == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end
endmodule
